// ----- rtl/fat_address_converter_assert.svh -----
// Assertion macros for the FAT address converter.
// They sample on i_clk and are disabled while i_rst_n is low.
`ifndef FAT_ADDRESS_CONVERTER_ASSERT_SVH
`define FAT_ADDRESS_CONVERTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FAC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/fac_pkg.sv -----
package fac_pkg;

    localparam int PART_W     = 32;
    localparam int RESV_W     = 16;
    localparam int FATC_W     = 8;
    localparam int SPF_W      = 32;
    localparam int SPC_W      = 8;
    localparam int SB_W       = 17;
    localparam int ADDR_IN_W  = 32;
    localparam int ADDR_W     = 48;
    localparam int HALF_W     = ADDR_W / 2;
    localparam int FATS_W     = FATC_W + SPF_W;
    localparam int CPROD_W    = ADDR_IN_W + 1 + SPC_W + 1;
    localparam int PROD_W     = HALF_W + SB_W;
    localparam int KIND_W     = 2;
    localparam int ERR_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int DIV_W      = 42;
    localparam int DIV_BITS   = 6;
    localparam int DIV_STAGES = DIV_W / DIV_BITS;

    localparam int FIRST_DATA_CLUSTER   = 2;
    localparam int DEFAULT_SECTOR_BYTES = 512;

    localparam logic [CFG_IDX_W-1:0] REG_PARTITION_START     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED_SECTORS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAT_COPIES          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECTORS_PER_FAT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SECTORS_PER_CLUSTER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SECTOR_BYTES        = 3'd5;

    localparam logic [KIND_W-1:0] KIND_LOGICAL  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PHYSICAL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLUSTER  = 2'd2;

    localparam logic [KIND_W-1:0] KNOWN_CLUSTER  = 2'd0;
    localparam logic [KIND_W-1:0] KNOWN_LOGICAL  = 2'd1;
    localparam logic [KIND_W-1:0] KNOWN_PHYSICAL = 2'd2;

    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_COMBO    = 2'd1;
    localparam logic [ERR_W-1:0] ERR_ZERO_SPC = 2'd2;

    typedef enum logic [2:0] {
        OP_LOG_FROM_CLU,
        OP_LOG_FROM_PHY,
        OP_PHY_FROM_CLU,
        OP_PHY_FROM_LOG,
        OP_CLU_FROM_LOG,
        OP_CLU_FROM_PHY,
        OP_INVALID
    } t_op;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [KIND_W-1:0]    known_kind;
        logic [ADDR_IN_W-1:0] address_value;
        logic                 byte_output;
    } t_in_word;

    typedef struct packed {
        logic signed [ADDR_W-1:0] address_out;
        logic [ERR_W-1:0]         error_code;
    } t_out_word;

    typedef struct packed {
        logic [ADDR_W-1:0] sum;
        logic [ERR_W-1:0]  err;
        logic              cluster;
        logic              bytes;
    } t_div_side;

endpackage

// ----- rtl/fac_div.sv -----
module fac_div import fac_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [ADDR_W-1:0] i_dividend,
    input  logic [SPC_W-1:0]  i_divisor,
    input  t_div_side         i_side,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [DIV_W-1:0]  o_quotient,
    output logic              o_neg,
    output t_div_side         o_side
);

    typedef struct packed {
        logic [DIV_W-1:0] acc;
        logic [SPC_W-1:0] rem;
    } t_div_state;

    // Restoring division, DIV_BITS quotient bits per stage. The quotient
    // bits shift into the low end of the dividend register.
    function automatic t_div_state div_step(t_div_state s, logic [SPC_W-1:0] d);
        t_div_state r;
        logic [SPC_W:0] t;
        r = s;
        for (int b = 0; b < DIV_BITS; b++) begin
            t = {r.rem, r.acc[DIV_W-1]};
            r.acc = {r.acc[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, d}) begin
                t = t - {1'b0, d};
                r.acc[0] = 1'b1;
            end
            r.rem = t[SPC_W-1:0];
        end
        return r;
    endfunction

    logic [DIV_STAGES:0] r_v;
    logic [DIV_STAGES:0] w_en;
    t_div_state          r_st [0:DIV_STAGES];
    logic                r_neg [0:DIV_STAGES];
    t_div_side           r_side [0:DIV_STAGES];
    logic [ADDR_W-1:0]   w_mag;
    t_div_state          n_load;

    assign w_en[DIV_STAGES] = !r_v[DIV_STAGES] || !i_stall;
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_en
        assign w_en[k] = !r_v[k] || w_en[k+1];
    end

    assign w_mag = i_dividend[ADDR_W-1] ? (~i_dividend + ADDR_W'(1)) : i_dividend;

    always_comb begin
        n_load.acc = w_mag[DIV_W-1:0];
        n_load.rem = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k <= DIV_STAGES; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_st[0]   <= n_load;
            r_neg[0]  <= i_dividend[ADDR_W-1];
            r_side[0] <= i_side;
        end
        for (int k = 1; k <= DIV_STAGES; k++) begin
            if (w_en[k]) begin
                r_st[k]   <= div_step(r_st[k-1], i_divisor);
                r_neg[k]  <= r_neg[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_stall    = !w_en[0];
    assign o_valid    = r_v[DIV_STAGES];
    assign o_quotient = r_st[DIV_STAGES].acc;
    assign o_neg      = r_neg[DIV_STAGES];
    assign o_side     = r_side[DIV_STAGES];

endmodule

// ----- rtl/fat_address_converter.sv -----
// Converts one FAT volume address per word between logical sector, physical
// sector and cluster number, using the volume geometry held in six write-only
// registers, and optionally scales the result by the sector size. The block
// takes one word every clock cycle while the output is not stalled; words
// leave in the order they came in. The pipeline holds the cluster divider, a
// load stage and seven stages of six quotient bits each, with three stages in
// front of it and three behind it. Every word passes through the divider
// whatever its target form. A stall on the output closes the gaps between
// words before it reaches the input. Registers may only be written while no
// word is in flight.
module fat_address_converter import fac_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_word              i_word,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_word             o_word
);

    typedef struct packed {
        t_op                 op;
        logic [ERR_W-1:0]    err;
        logic [FATS_W-1:0]   fats;
        logic [CPROD_W-1:0]  cprod;
        logic [ADDR_IN_W-1:0] addr;
        logic                bytes;
    } t_s1;

    typedef struct packed {
        logic [ADDR_W-1:0] x;
        logic [ADDR_W-1:0] y;
        logic              sub;
        logic [ERR_W-1:0]  err;
        logic              cluster;
        logic              bytes;
    } t_s2;

    typedef struct packed {
        logic [ADDR_W-1:0] res;
        logic [ERR_W-1:0]  err;
        logic              bytes;
    } t_post;

    typedef struct packed {
        logic [PROD_W-1:0] lo;
        logic [HALF_W-1:0] hi;
        logic [ADDR_W-1:0] res;
        logic [ERR_W-1:0]  err;
        logic              bytes;
    } t_mul;

    logic [PART_W-1:0] r_part;
    logic [RESV_W-1:0] r_resv;
    logic [FATC_W-1:0] r_fatc;
    logic [SPF_W-1:0]  r_spf;
    logic [SPC_W-1:0]  r_spc;
    logic [SB_W-1:0]   r_sb;

    logic r_v1, r_v2, r_v3, r_post_v, r_mul_v, r_out_v;
    logic w_en1, w_en2, w_en3, w_en_post, w_en_mul, w_en_out;

    t_s1       r_s1, n_s1;
    t_s2       r_s2, n_s2;
    t_div_side r_s3, n_s3;
    t_post     r_post, n_post;
    t_mul      r_mul, n_mul;
    t_out_word r_out, n_out;

    logic signed [ADDR_IN_W:0] w_cl;
    logic [ADDR_W-1:0]         w_geo;
    logic                      w_div_stall;
    logic                      w_div_v;
    logic [DIV_W-1:0]          w_quot;
    logic                      w_neg;
    t_div_side                 w_side;
    logic [ADDR_W-1:0]         w_q48;
    logic [PROD_W-1:0]         w_hi_full;
    logic [ADDR_W-1:0]         w_scaled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part <= '0;
            r_resv <= '0;
            r_fatc <= '0;
            r_spf  <= '0;
            r_spc  <= SPC_W'(1);
            r_sb   <= SB_W'(DEFAULT_SECTOR_BYTES);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PARTITION_START: begin
                    r_part <= i_cfg_data[PART_W-1:0];
                end
                REG_RESERVED_SECTORS: begin
                    r_resv <= i_cfg_data[RESV_W-1:0];
                end
                REG_FAT_COPIES: begin
                    r_fatc <= i_cfg_data[FATC_W-1:0];
                end
                REG_SECTORS_PER_FAT: begin
                    r_spf <= i_cfg_data[SPF_W-1:0];
                end
                REG_SECTORS_PER_CLUSTER: begin
                    r_spc <= i_cfg_data[SPC_W-1:0];
                end
                REG_SECTOR_BYTES: begin
                    r_sb <= i_cfg_data[SB_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign w_en_out  = !r_out_v || !i_stall;
    assign w_en_mul  = !r_mul_v || w_en_out;
    assign w_en_post = !r_post_v || w_en_mul;
    assign w_en3     = !r_v3 || !w_div_stall;
    assign w_en2     = !r_v2 || w_en3;
    assign w_en1     = !r_v1 || w_en2;
    assign o_stall   = !w_en1;

    // Decode the conversion and form the two products.
    assign w_cl = $signed({1'b0, i_word.address_value}) - (ADDR_IN_W + 1)'(FIRST_DATA_CLUSTER);

    always_comb begin
        n_s1.op = OP_INVALID;
        if (i_word.kind == KIND_LOGICAL && i_word.known_kind == KNOWN_CLUSTER) begin
            n_s1.op = OP_LOG_FROM_CLU;
        end else if (i_word.kind == KIND_LOGICAL && i_word.known_kind == KNOWN_PHYSICAL) begin
            n_s1.op = OP_LOG_FROM_PHY;
        end else if (i_word.kind == KIND_PHYSICAL && i_word.known_kind == KNOWN_CLUSTER) begin
            n_s1.op = OP_PHY_FROM_CLU;
        end else if (i_word.kind == KIND_PHYSICAL && i_word.known_kind == KNOWN_LOGICAL) begin
            n_s1.op = OP_PHY_FROM_LOG;
        end else if (i_word.kind == KIND_CLUSTER && i_word.known_kind == KNOWN_LOGICAL) begin
            n_s1.op = OP_CLU_FROM_LOG;
        end else if (i_word.kind == KIND_CLUSTER && i_word.known_kind == KNOWN_PHYSICAL) begin
            n_s1.op = OP_CLU_FROM_PHY;
        end
        if (n_s1.op == OP_INVALID) begin
            n_s1.err = ERR_COMBO;
        end else if ((n_s1.op == OP_CLU_FROM_LOG || n_s1.op == OP_CLU_FROM_PHY)
                     && r_spc == '0) begin
            n_s1.err = ERR_ZERO_SPC;
        end else begin
            n_s1.err = ERR_NONE;
        end
        n_s1.fats  = FATS_W'(r_fatc) * FATS_W'(r_spf);
        n_s1.cprod = CPROD_W'(w_cl) * CPROD_W'($signed({1'b0, r_spc}));
        n_s1.addr  = i_word.address_value;
        n_s1.bytes = i_word.byte_output;
    end

    // Volume geometry sum and the operands of the final add.
    always_comb begin
        w_geo = ADDR_W'(r_resv) + ADDR_W'(r_s1.fats)
              + ((r_s1.op == OP_PHY_FROM_CLU || r_s1.op == OP_CLU_FROM_PHY)
                 ? ADDR_W'(r_part) : {ADDR_W{1'b0}});
        n_s2.x   = {ADDR_W{1'b0}};
        n_s2.y   = {ADDR_W{1'b0}};
        n_s2.sub = 1'b0;
        case (r_s1.op)
            OP_LOG_FROM_CLU, OP_PHY_FROM_CLU: begin
                n_s2.x = w_geo;
                n_s2.y = ADDR_W'($signed(r_s1.cprod));
            end
            OP_LOG_FROM_PHY: begin
                n_s2.x   = ADDR_W'(r_s1.addr);
                n_s2.y   = ADDR_W'(r_part);
                n_s2.sub = 1'b1;
            end
            OP_PHY_FROM_LOG: begin
                n_s2.x = ADDR_W'(r_s1.addr);
                n_s2.y = ADDR_W'(r_part);
            end
            OP_CLU_FROM_LOG, OP_CLU_FROM_PHY: begin
                n_s2.x   = ADDR_W'(r_s1.addr);
                n_s2.y   = w_geo;
                n_s2.sub = 1'b1;
            end
            default: begin
            end
        endcase
        n_s2.err     = r_s1.err;
        n_s2.cluster = (r_s1.op == OP_CLU_FROM_LOG || r_s1.op == OP_CLU_FROM_PHY);
        n_s2.bytes   = r_s1.bytes;
    end

    always_comb begin
        n_s3.sum     = r_s2.sub ? (r_s2.x - r_s2.y) : (r_s2.x + r_s2.y);
        n_s3.err     = r_s2.err;
        n_s3.cluster = r_s2.cluster;
        n_s3.bytes   = r_s2.bytes;
    end

    fac_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_v3),
        .o_stall    (w_div_stall),
        .i_dividend (r_s3.sum),
        .i_divisor  (r_spc),
        .i_side     (r_s3),
        .o_valid    (w_div_v),
        .i_stall    (!w_en_post),
        .o_quotient (w_quot),
        .o_neg      (w_neg),
        .o_side     (w_side)
    );

    // Apply the sign of the numerator and the first data cluster offset.
    assign w_q48 = ADDR_W'(w_quot);

    always_comb begin
        if (w_side.cluster) begin
            n_post.res = w_neg ? (ADDR_W'(FIRST_DATA_CLUSTER) - w_q48)
                               : (w_q48 + ADDR_W'(FIRST_DATA_CLUSTER));
        end else begin
            n_post.res = w_side.sum;
        end
        n_post.err   = w_side.err;
        n_post.bytes = w_side.bytes;
    end

    // Byte scaling is split into two half-width partial products.
    assign w_hi_full = PROD_W'(r_post.res[ADDR_W-1:HALF_W]) * PROD_W'(r_sb);

    always_comb begin
        n_mul.lo    = PROD_W'(r_post.res[HALF_W-1:0]) * PROD_W'(r_sb);
        n_mul.hi    = w_hi_full[HALF_W-1:0];
        n_mul.res   = r_post.res;
        n_mul.err   = r_post.err;
        n_mul.bytes = r_post.bytes;
    end

    assign w_scaled = ADDR_W'(r_mul.lo) + {r_mul.hi, {HALF_W{1'b0}}};

    always_comb begin
        if (r_mul.err != ERR_NONE) begin
            n_out.address_out = '0;
        end else if (r_mul.bytes) begin
            n_out.address_out = w_scaled;
        end else begin
            n_out.address_out = r_mul.res;
        end
        n_out.error_code = r_mul.err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_post_v <= 1'b0;
            r_mul_v  <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
            if (w_en_post) begin
                r_post_v <= w_div_v;
            end
            if (w_en_mul) begin
                r_mul_v <= r_post_v;
            end
            if (w_en_out) begin
                r_out_v <= r_mul_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1 <= n_s1;
        end
        if (w_en2) begin
            r_s2 <= n_s2;
        end
        if (w_en3) begin
            r_s3 <= n_s3;
        end
        if (w_en_post) begin
            r_post <= n_post;
        end
        if (w_en_mul) begin
            r_mul <= n_mul;
        end
        if (w_en_out) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_v;
    assign o_word  = r_out;

`include "fat_address_converter_assert.svh"

    `FAC_ASSERT_NOW(a_stall_source, o_stall, o_valid && i_stall, "input stalled with output free")
    `FAC_ASSERT_NEXT(a_accept_enters, i_valid && !o_stall, r_v1, "accepted word lost at entry")
    `FAC_ASSERT_NOW(a_error_zero, o_valid && o_word.error_code != ERR_NONE, o_word.address_out == '0, "error word with nonzero address")

endmodule
